// ===== rtl/core/lattice_neighbor_index_unit_defines.svh =====
// ---------------------------------------------------------------------------
// lattice neighbor index unit - assertion macros
// concurrent check wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef LATTICE_NEIGHBOR_INDEX_UNIT_DEFINES_SVH
`define LATTICE_NEIGHBOR_INDEX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LNI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LNI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LNI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LNI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lni_pkg.sv =====
// ---------------------------------------------------------------------------
// lni_pkg
// shared widths, lane grouping constants, register codes and types
// ---------------------------------------------------------------------------
package lni_pkg;

	localparam int unsigned LANES = 8;
	localparam int unsigned GX = (LANES < 2) ? 1 : 2;
	localparam int unsigned GY = (LANES < 4) ? 1 : 2;
	localparam int unsigned GZ = (LANES < 8) ? 1 : 2;
	localparam int unsigned GT = (LANES < 16) ? 1 : 2;

	// bit position of each lane digit inside the lane number
	localparam int unsigned POS_Y = GX - 1;
	localparam int unsigned POS_Z = POS_Y + GY - 1;
	localparam int unsigned POS_T = POS_Z + GZ - 1;

	localparam int unsigned IDX_W    = 16;
	localparam int unsigned LANE_W   = 4;
	localparam int unsigned DIR_W    = 4;
	localparam int unsigned EXT_W    = 7;
	localparam int unsigned STRIDE_W = 16;
	localparam int unsigned CRD_W    = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DIV_STAGES = 4;
	localparam int unsigned EXT_MAX    = 64;

	localparam logic [EXT_W-1:0]    RST_HALF_X     = 7'd4;
	localparam logic [EXT_W-1:0]    RST_Y          = 7'd8;
	localparam logic [EXT_W-1:0]    RST_Z          = 7'd8;
	localparam logic [EXT_W-1:0]    RST_T          = 7'd8;
	localparam logic [STRIDE_W-1:0] RST_XY_STRIDE  = 16'd32;
	localparam logic [STRIDE_W-1:0] RST_XYZ_STRIDE = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_X     = 3'd0,
		CFG_Y          = 3'd1,
		CFG_Z          = 3'd2,
		CFG_T          = 3'd3,
		CFG_XY_STRIDE  = 3'd4,
		CFG_XYZ_STRIDE = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIM_X = 2'd0,
		DIM_Y = 2'd1,
		DIM_Z = 2'd2,
		DIM_T = 2'd3
	} dim_t;

	// clamped local extents, all in 1..64
	typedef struct packed {
		logic [EXT_W-1:0] hx;
		logic [EXT_W-1:0] ye;
		logic [EXT_W-1:0] ze;
		logic [EXT_W-1:0] te;
	} ext_t;

	function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] raw);
		logic [EXT_W-1:0] r;
		r = raw;
		if (raw == '0)
			r = EXT_W'(1);
		else if (raw > EXT_W'(EXT_MAX))
			r = EXT_W'(EXT_MAX);
		return r;
	endfunction

endpackage

// ===== rtl/core/lni_div.sv =====
// ---------------------------------------------------------------------------
// lni_div
// pipelined restoring divider, 16-bit dividend by a 1..64 divisor
// ---------------------------------------------------------------------------
`include "lattice_neighbor_index_unit_defines.svh"

module lni_div #(
	parameter int unsigned SIDE_W = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [lni_pkg::IDX_W-1:0]  dividend,
	input  logic [lni_pkg::EXT_W-1:0]  divisor,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_valid,
	output logic [lni_pkg::IDX_W-1:0]  quotient,
	output logic [lni_pkg::EXT_W-1:0]  remainder,
	output logic [SIDE_W-1:0]          side_out
);
	import lni_pkg::*;

	localparam int unsigned BITS = IDX_W / DIV_STAGES;
	localparam int unsigned LAST = DIV_STAGES - 1;

	logic [DIV_STAGES-1:0] vld_s;
	logic [EXT_W-1:0]      rem_s   [DIV_STAGES];
	logic [IDX_W-1:0]      dq_s    [DIV_STAGES];
	logic [SIDE_W-1:0]     side_s  [DIV_STAGES];
	logic                  vld_src [DIV_STAGES];
	logic [EXT_W-1:0]      rem_src [DIV_STAGES];
	logic [IDX_W-1:0]      dq_src  [DIV_STAGES];
	logic [SIDE_W-1:0]     side_src[DIV_STAGES];
	logic [EXT_W-1:0]      rem_nx  [DIV_STAGES];
	logic [IDX_W-1:0]      dq_nx   [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			if (k == 0) begin : g_first
				assign vld_src[k]  = in_valid;
				assign rem_src[k]  = '0;
				assign dq_src[k]   = dividend;
				assign side_src[k] = side_in;
			end else begin : g_next
				assign vld_src[k]  = vld_s[k-1];
				assign rem_src[k]  = rem_s[k-1];
				assign dq_src[k]   = dq_s[k-1];
				assign side_src[k] = side_s[k-1];
			end

			// dividend bits shift out the top, quotient bits shift in the bottom
			always_comb begin
				logic [EXT_W:0]   part;
				logic [EXT_W-1:0] r;
				logic [IDX_W-1:0] d;
				r = rem_src[k];
				d = dq_src[k];
				for (int b = 0; b < BITS; b++) begin
					part = {r, d[IDX_W-1]};
					d = {d[IDX_W-2:0], 1'b0};
					if (part >= {1'b0, divisor}) begin
						part = part - {1'b0, divisor};
						d[0] = 1'b1;
					end
					r = part[EXT_W-1:0];
				end
				rem_nx[k] = r;
				dq_nx[k]  = d;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_src[k];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= rem_nx[k];
					dq_s[k]   <= dq_nx[k];
					side_s[k] <= side_src[k];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[LAST];
	assign quotient  = dq_s[LAST];
	assign remainder = rem_s[LAST];
	assign side_out  = side_s[LAST];

	`LNI_ASSERT_IMP(a_rem_below_divisor, clk, arst_n, out_valid, remainder < divisor, "lni_div: remainder not below divisor")

endmodule

// ===== rtl/core/lni_coord.sv =====
// ---------------------------------------------------------------------------
// lni_coord
// rebuilds global checkerboard coordinates, takes the periodic step,
// folds the result back into lane digits and local coordinates
// ---------------------------------------------------------------------------
`include "lattice_neighbor_index_unit_defines.svh"

module lni_coord (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  lni_pkg::ext_t              ext,
	input  logic                       in_valid,
	input  logic [lni_pkg::LANE_W-1:0] lane,
	input  logic                       parity,
	input  logic [lni_pkg::DIR_W-1:0]  direction,
	input  logic [lni_pkg::EXT_W-1:0]  x2,
	input  logic [lni_pkg::EXT_W-1:0]  y2,
	input  logic [lni_pkg::EXT_W-1:0]  z2,
	input  logic [lni_pkg::EXT_W-1:0]  t2,
	output logic                       out_valid,
	output logic                       out_parity,
	output logic [3:0]                 out_digits,
	output logic [lni_pkg::EXT_W-1:0]  out_x2,
	output logic [lni_pkg::EXT_W-1:0]  out_y2,
	output logic [lni_pkg::EXT_W-1:0]  out_z2,
	output logic [lni_pkg::EXT_W-1:0]  out_t2
);
	import lni_pkg::*;

	function automatic logic [CRD_W-1:0] wrap_step(
		input logic [CRD_W-1:0] c,
		input logic [CRD_W-1:0] n,
		input logic             hop3,
		input logic             down
	);
		logic signed [CRD_W+1:0] v;
		logic signed [CRD_W+1:0] ns;
		logic signed [CRD_W+1:0] hop;
		ns  = signed'({2'b00, n});
		hop = hop3 ? (CRD_W+2)'(3) : (CRD_W+2)'(1);
		if (down) begin
			v = signed'({2'b00, c}) - hop;
			for (int i = 0; i < 3; i++)
				if (v < 0)
					v = v + ns;
		end else begin
			v = signed'({2'b00, c}) + hop;
			for (int i = 0; i < 3; i++)
				if (v >= ns)
					v = v - ns;
		end
		return v[CRD_W-1:0];
	endfunction

	// global extents
	logic [CRD_W-1:0] nx, ny, nz, nt;
	assign nx = (GX == 2) ? {ext.hx, 2'b00} : {1'b0, ext.hx, 1'b0};
	assign ny = (GY == 2) ? {1'b0, ext.ye, 1'b0} : {2'b00, ext.ye};
	assign nz = (GZ == 2) ? {1'b0, ext.ze, 1'b0} : {2'b00, ext.ze};
	assign nt = (GT == 2) ? {1'b0, ext.te, 1'b0} : {2'b00, ext.te};

	// stage 1: rebuild coordinates
	logic              vld_s1;
	logic [DIR_W-1:0]  dir_s1;
	logic [CRD_W-1:0]  x_s1, y_s1, z_s1, t_s1;
	logic              dx1, dy1, dz1, dt1;
	logic [CRD_W-1:0]  xs_c, y_c, z_c, t_c;

	always_comb begin
		dx1 = (GX == 2) ? lane[0]     : 1'b0;
		dy1 = (GY == 2) ? lane[POS_Y] : 1'b0;
		dz1 = (GZ == 2) ? lane[POS_Z] : 1'b0;
		dt1 = (GT == 2) ? lane[POS_T] : 1'b0;
		xs_c = CRD_W'(x2) + (dx1 ? CRD_W'(ext.hx) : '0);
		y_c  = CRD_W'(y2) + (dy1 ? CRD_W'(ext.ye) : '0);
		z_c  = CRD_W'(z2) + (dz1 ? CRD_W'(ext.ze) : '0);
		t_c  = CRD_W'(t2) + (dt1 ? CRD_W'(ext.te) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1 <= direction;
			x_s1   <= {xs_c[CRD_W-2:0], y_c[0] ^ z_c[0] ^ t_c[0] ^ parity};
			y_s1   <= y_c;
			z_s1   <= z_c;
			t_s1   <= t_c;
		end
	end

	// stage 2: periodic step along one dimension
	logic              vld_s2;
	logic [CRD_W-1:0]  x_s2, y_s2, z_s2, t_s2;
	logic [CRD_W-1:0]  x_n, y_n, z_n, t_n;
	dim_t              dim;

	assign dim = dim_t'(dir_s1[2:1]);

	always_comb begin
		x_n = x_s1;
		y_n = y_s1;
		z_n = z_s1;
		t_n = t_s1;
		unique case (dim)
			DIM_X: x_n = wrap_step(x_s1, nx, dir_s1[3], dir_s1[0]);
			DIM_Y: y_n = wrap_step(y_s1, ny, dir_s1[3], dir_s1[0]);
			DIM_Z: z_n = wrap_step(z_s1, nz, dir_s1[3], dir_s1[0]);
			DIM_T: t_n = wrap_step(t_s1, nt, dir_s1[3], dir_s1[0]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_n;
			y_s2 <= y_n;
			z_s2 <= z_n;
			t_s2 <= t_n;
		end
	end

	// stage 3: split into lane digit and local coordinate, each quotient is 0 or 1
	logic              vld_s3;
	logic              par_s3;
	logic [3:0]        dig_s3;
	logic [EXT_W-1:0]  x2_s3, y2_s3, z2_s3, t2_s3;
	logic [CRD_W-1:0]  nxh;
	logic              fx, fy, fz, ft;

	assign nxh = {1'b0, x_s2[CRD_W-1:1]};
	assign fx  = nxh  >= CRD_W'(ext.hx);
	assign fy  = y_s2 >= CRD_W'(ext.ye);
	assign fz  = z_s2 >= CRD_W'(ext.ze);
	assign ft  = t_s2 >= CRD_W'(ext.te);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s3 <= x_s2[0] ^ y_s2[0] ^ z_s2[0] ^ t_s2[0];
			dig_s3 <= {ft, fz, fy, fx};
			x2_s3  <= EXT_W'(nxh  - (fx ? CRD_W'(ext.hx) : '0));
			y2_s3  <= EXT_W'(y_s2 - (fy ? CRD_W'(ext.ye) : '0));
			z2_s3  <= EXT_W'(z_s2 - (fz ? CRD_W'(ext.ze) : '0));
			t2_s3  <= EXT_W'(t_s2 - (ft ? CRD_W'(ext.te) : '0));
		end
	end

	assign out_valid  = vld_s3;
	assign out_parity = par_s3;
	assign out_digits = dig_s3;
	assign out_x2     = x2_s3;
	assign out_y2     = y2_s3;
	assign out_z2     = z2_s3;
	assign out_t2     = t2_s3;

	`LNI_ASSERT_IMP(a_step_in_range, clk, arst_n, vld_s2, (x_s2 < nx) && (y_s2 < ny) && (z_s2 < nz) && (t_s2 < nt), "lni_coord: stepped coordinate outside lattice")

endmodule

// ===== rtl/core/lni_index.sv =====
// ---------------------------------------------------------------------------
// lni_index
// padded stride products, then final sum and lane number
// ---------------------------------------------------------------------------
module lni_index (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [lni_pkg::EXT_W-1:0]     hx,
	input  logic [lni_pkg::STRIDE_W-1:0]  xy_stride,
	input  logic [lni_pkg::STRIDE_W-1:0]  xyz_stride,
	input  logic                          in_valid,
	input  logic                          in_parity,
	input  logic [3:0]                    in_digits,
	input  logic [lni_pkg::EXT_W-1:0]     x2,
	input  logic [lni_pkg::EXT_W-1:0]     y2,
	input  logic [lni_pkg::EXT_W-1:0]     z2,
	input  logic [lni_pkg::EXT_W-1:0]     t2,
	output logic                          out_valid,
	output logic [lni_pkg::IDX_W-1:0]     out_index,
	output logic [lni_pkg::LANE_W-1:0]    out_lane,
	output logic                          out_parity
);
	import lni_pkg::*;

	// stage 1: products, kept to the index width
	logic              vld_s1;
	logic              par_s1;
	logic [3:0]        dig_s1;
	logic [IDX_W-1:0]  pt_s1, pz_s1, py_s1, px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s1 <= in_parity;
			dig_s1 <= in_digits;
			pt_s1  <= IDX_W'(IDX_W'(t2) * xyz_stride);
			pz_s1  <= IDX_W'(IDX_W'(z2) * xy_stride);
			py_s1  <= IDX_W'(IDX_W'(y2) * IDX_W'(hx));
			px_s1  <= IDX_W'(x2);
		end
	end

	// stage 2: output register
	logic              vld_s2;
	logic              par_s2;
	logic [LANE_W-1:0] lane_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [LANE_W-1:0] lane_c;

	// a digit of a dimension with one lane group is always zero
	assign lane_c = LANE_W'(dig_s1[0])
		| (LANE_W'(dig_s1[1]) << POS_Y)
		| (LANE_W'(dig_s1[2]) << POS_Z)
		| (LANE_W'(dig_s1[3]) << POS_T);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s2  <= par_s1;
			lane_s2 <= lane_c;
			idx_s2  <= pt_s1 + pz_s1 + py_s1 + px_s1;
		end
	end

	assign out_valid  = vld_s2;
	assign out_index  = idx_s2;
	assign out_lane   = lane_s2;
	assign out_parity = par_s2;

endmodule

// ===== rtl/core/lattice_neighbor_index_unit.sv =====
// ---------------------------------------------------------------------------
// lattice_neighbor_index_unit
// neighbor address generator for a checkerboarded 4-d lattice with fused lanes
// ---------------------------------------------------------------------------
// Takes one site (index, lane, parity) and a direction per cycle and returns
// the neighbor's fused site index, lane and parity one or three hops away with
// periodic wrap. Throughput is one item per clock. The site passes through the
// four chained 4-stage dividers that split the site index by the local extents,
// then the coordinate rebuild, step and fold stages, then the stride product
// and final sum stages. A stall on the output freezes the whole pipeline.
// Extent registers outside 1..64 act as clamped; write them only while idle.
`include "lattice_neighbor_index_unit_defines.svh"

module lattice_neighbor_index_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lni_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lni_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lni_pkg::IDX_W-1:0]       site_index,
	input  logic [lni_pkg::LANE_W-1:0]      lane,
	input  logic                            parity,
	input  logic [lni_pkg::DIR_W-1:0]       direction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lni_pkg::IDX_W-1:0]       neighbor_index,
	output logic [lni_pkg::LANE_W-1:0]      neighbor_lane,
	output logic                            neighbor_parity
);
	import lni_pkg::*;

	localparam int unsigned SW0 = DIR_W + 1 + LANE_W;
	localparam int unsigned SW1 = SW0 + EXT_W;
	localparam int unsigned SW2 = SW1 + EXT_W;
	localparam int unsigned SW3 = SW2 + EXT_W;

	logic [EXT_W-1:0]    half_x_q, y_ext_q, z_ext_q, t_ext_q;
	logic [STRIDE_W-1:0] xy_stride_q, xyz_stride_q;
	ext_t                ext;
	logic                en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q     <= RST_HALF_X;
			y_ext_q      <= RST_Y;
			z_ext_q      <= RST_Z;
			t_ext_q      <= RST_T;
			xy_stride_q  <= RST_XY_STRIDE;
			xyz_stride_q <= RST_XYZ_STRIDE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_HALF_X:     half_x_q     <= cfg_data[EXT_W-1:0];
				CFG_Y:          y_ext_q      <= cfg_data[EXT_W-1:0];
				CFG_Z:          z_ext_q      <= cfg_data[EXT_W-1:0];
				CFG_T:          t_ext_q      <= cfg_data[EXT_W-1:0];
				CFG_XY_STRIDE:  xy_stride_q  <= cfg_data;
				CFG_XYZ_STRIDE: xyz_stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ext = {clamp_ext(half_x_q), clamp_ext(y_ext_q), clamp_ext(z_ext_q),
		clamp_ext(t_ext_q)};

	// the whole pipeline advances unless the output holds a result not yet taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic              v0, v1, v2, v3;
	logic [IDX_W-1:0]  q0, q1, q2, q3;
	logic [EXT_W-1:0]  r0, r1, r2, r3;
	logic [SW0-1:0]    sd0;
	logic [SW1-1:0]    sd1;
	logic [SW2-1:0]    sd2;
	logic [SW3-1:0]    sd3;

	lni_div #(.SIDE_W(SW0)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.dividend(site_index), .divisor(ext.hx), .side_in({direction, parity, lane}),
		.out_valid(v0), .quotient(q0), .remainder(r0), .side_out(sd0)
	);

	lni_div #(.SIDE_W(SW1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v0),
		.dividend(q0), .divisor(ext.ye), .side_in({sd0, r0}),
		.out_valid(v1), .quotient(q1), .remainder(r1), .side_out(sd1)
	);

	lni_div #(.SIDE_W(SW2)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1),
		.dividend(q1), .divisor(ext.ze), .side_in({sd1, r1}),
		.out_valid(v2), .quotient(q2), .remainder(r2), .side_out(sd2)
	);

	// only the remainder matters here: the t part wraps modulo t extent
	lni_div #(.SIDE_W(SW3)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v2),
		.dividend(q2), .divisor(ext.te), .side_in({sd2, r2}),
		.out_valid(v3), .quotient(q3), .remainder(r3), .side_out(sd3)
	);

	// side bundle layout, low to high: z2, y2, x2, lane, parity, direction
	logic [EXT_W-1:0]  sx2, sy2, sz2;
	logic [LANE_W-1:0] s_lane;
	logic              s_par;
	logic [DIR_W-1:0]  s_dir;

	assign {s_dir, s_par, s_lane, sx2, sy2, sz2} = sd3;

	logic              cv, cpar;
	logic [3:0]        cdig;
	logic [EXT_W-1:0]  cx2, cy2, cz2, ct2;

	lni_coord u_coord (
		.clk(clk), .arst_n(arst_n), .en(en), .ext(ext),
		.in_valid(v3), .lane(s_lane), .parity(s_par), .direction(s_dir),
		.x2(sx2), .y2(sy2), .z2(sz2), .t2(r3),
		.out_valid(cv), .out_parity(cpar), .out_digits(cdig),
		.out_x2(cx2), .out_y2(cy2), .out_z2(cz2), .out_t2(ct2)
	);

	lni_index u_index (
		.clk(clk), .arst_n(arst_n), .en(en), .hx(ext.hx),
		.xy_stride(xy_stride_q), .xyz_stride(xyz_stride_q),
		.in_valid(cv), .in_parity(cpar), .in_digits(cdig),
		.x2(cx2), .y2(cy2), .z2(cz2), .t2(ct2),
		.out_valid(out_valid), .out_index(neighbor_index),
		.out_lane(neighbor_lane), .out_parity(neighbor_parity)
	);

	`LNI_ASSERT_IMP(a_lane_in_groups, clk, arst_n, out_valid, 32'(neighbor_lane) < LANES || LANES >= 16, "lane outside lane groups")
	`LNI_ASSERT_NXT(a_cfg_hold, clk, arst_n, !cfg_valid, $stable(xy_stride_q) && $stable(half_x_q), "config changed without a transfer")
	`LNI_ASSERT_IMP(a_tail_extent_ok, clk, arst_n, v3, (ext.te != '0) && (r3 < ext.te) && !$isunknown(q3), "t divider out of range")

endmodule
